[src/sha1bsh_pkg.sv]
// shared types, constants and round functions for the sha-1 byte stream hasher
// no dependencies; the front, queue, core, top and bench refer to this package by scoped names
`default_nettype none

package sha1bsh_pkg;

  // queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // compression and digest geometry
  localparam int unsigned BlkWords = 16;
  localparam int unsigned DigWords = 5;
  localparam int unsigned RndW     = 7;
  localparam int unsigned FillW    = 6;
  localparam int unsigned WordNumW = 3;

  localparam logic [RndW-1:0]     LastRound = RndW'(79);
  localparam logic [FillW-1:0]    LastByte  = FillW'(63);
  localparam logic [FillW-1:0]    LenOffset = FillW'(56);
  localparam logic [WordNumW-1:0] LastWord  = WordNumW'(DigWords - 1);
  localparam logic [7:0]          PadMark   = 8'h80;
  localparam logic [63:0]         BitsPerByte = 64'd8;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_END      = 2'd1,
    OP_BYTE_END = 2'd2
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_PAD   = 3'd1,
    ST_ROUND = 3'd2,
    ST_ADD   = 3'd3,
    ST_EMIT  = 3'd4
  } state_e;

  function automatic word_t init_word(input logic [WordNumW-1:0] idx);
    word_t w;
    begin
      unique case (idx)
        3'd0:    w = 32'h67452301;
        3'd1:    w = 32'hEFCDAB89;
        3'd2:    w = 32'h98BADCFE;
        3'd3:    w = 32'h10325476;
        default: w = 32'hC3D2E1F0;
      endcase
      return w;
    end
  endfunction

  function automatic word_t round_f(input logic [RndW-1:0] rnd, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    begin
      priority if (rnd < RndW'(20)) begin
        f = (b & c) | (~b & d);
      end else if (rnd < RndW'(40)) begin
        f = b ^ c ^ d;
      end else if (rnd < RndW'(60)) begin
        f = (b & c) | (b & d) | (c & d);
      end else begin
        f = b ^ c ^ d;
      end
      return f;
    end
  endfunction

  function automatic word_t round_k(input logic [RndW-1:0] rnd);
    word_t k;
    begin
      priority if (rnd < RndW'(20)) begin
        k = K0;
      end else if (rnd < RndW'(40)) begin
        k = K1;
      end else if (rnd < RndW'(60)) begin
        k = K2;
      end else begin
        k = K3;
      end
      return k;
    end
  endfunction

endpackage

`default_nettype wire

[src/sha1bsh_if.sv]
// valid/ready channel interfaces for message bytes in and digest words out
// no dependencies
`default_nettype none

interface sha1bsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1bsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;

  modport source (output valid, digest_word, word_number, final_word, input ready);
  modport sink   (input valid, digest_word, word_number, final_word, output ready);
endinterface

`default_nettype wire

[src/sha1bsh_front.sv]
// front end: takes input words, drops empty ones and classifies the rest
// depends on sha1bsh_pkg and sha1bsh_in_if
`default_nettype none

module sha1bsh_front (
  sha1bsh_in_if.sink           msg_i,
  input  sha1bsh_pkg::qstat_t  qstat_i,
  output logic                 push_o,
  output sha1bsh_pkg::qent_t   ent_o
);

  assign msg_i.ready = !qstat_i.full;

  always_comb begin
    ent_o.data = msg_i.data_byte;
    priority if (msg_i.byte_present && msg_i.end_of_message) begin
      ent_o.op = sha1bsh_pkg::OP_BYTE_END;
    end else if (msg_i.end_of_message) begin
      ent_o.op = sha1bsh_pkg::OP_END;
    end else begin
      ent_o.op = sha1bsh_pkg::OP_BYTE;
    end
  end

  // words with neither flag are taken and dropped
  assign push_o = msg_i.valid && msg_i.ready && (msg_i.byte_present || msg_i.end_of_message);

endmodule

`default_nettype wire

[src/sha1bsh_fifo.sv]
// short command queue between front and back
// depends on sha1bsh_pkg
`default_nettype none

module sha1bsh_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sha1bsh_pkg::qent_t  ent_i,
  input  logic                pop_i,
  output sha1bsh_pkg::qent_t  ent_o,
  output sha1bsh_pkg::qstat_t stat_o
);

  sha1bsh_pkg::qent_t                   mem_q [sha1bsh_pkg::QDepth];
  logic [sha1bsh_pkg::QPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [sha1bsh_pkg::QCntW-1:0]        cnt_q;
  logic                                 do_push, do_pop;

  assign stat_o.full  = (cnt_q == sha1bsh_pkg::QCntW'(sha1bsh_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign ent_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i)
    else $error("push into full queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sha1bsh_pkg::QCntW'(sha1bsh_pkg::QDepth))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

[src/sha1bsh_core.sv]
// back end: block buffer, padding, 80-round compression and digest output
// depends on sha1bsh_pkg and sha1bsh_out_if
`default_nettype none

module sha1bsh_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha1bsh_pkg::qstat_t qstat_i,
  input  sha1bsh_pkg::qent_t  ent_i,
  output logic                pop_o,
  sha1bsh_out_if.source       dgst_o
);

  sha1bsh_pkg::state_e state_q, state_d;

  sha1bsh_pkg::word_t blk_q [sha1bsh_pkg::BlkWords];
  sha1bsh_pkg::word_t h_q   [sha1bsh_pkg::DigWords];
  sha1bsh_pkg::word_t a_q, b_q, c_q, d_q, e_q;
  sha1bsh_pkg::word_t t_sum, w_new;

  logic [sha1bsh_pkg::RndW-1:0]     rnd_q;
  logic [sha1bsh_pkg::FillW-1:0]    fill_q;
  logic [63:0]                      len_q;
  logic [sha1bsh_pkg::WordNumW-1:0] emit_cnt_q;
  logic                             padding_q, mark_q, ovf_q, last_blk_q;

  logic       has_byte, has_end;
  logic       msg_we, byte_we, load_abcd, emit_go;
  logic [7:0] byte_val, pad_byte;

  assign has_byte = (ent_i.op == sha1bsh_pkg::OP_BYTE) || (ent_i.op == sha1bsh_pkg::OP_BYTE_END);
  assign has_end  = (ent_i.op == sha1bsh_pkg::OP_END) || (ent_i.op == sha1bsh_pkg::OP_BYTE_END);

  // padding byte: marker, then zeros, then big-endian length in the last eight slots
  always_comb begin
    priority if (mark_q) begin
      pad_byte = sha1bsh_pkg::PadMark;
    end else if (fill_q >= sha1bsh_pkg::LenOffset && !ovf_q) begin
      pad_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha1bsh_pkg::ST_IDLE: begin
        if (!qstat_i.empty) begin
          if (has_byte && fill_q == sha1bsh_pkg::LastByte) begin
            state_d = sha1bsh_pkg::ST_ROUND;
          end else if (has_end) begin
            state_d = sha1bsh_pkg::ST_PAD;
          end
        end
      end
      sha1bsh_pkg::ST_PAD: begin
        if (fill_q == sha1bsh_pkg::LastByte) begin
          state_d = sha1bsh_pkg::ST_ROUND;
        end
      end
      sha1bsh_pkg::ST_ROUND: begin
        if (rnd_q == sha1bsh_pkg::LastRound) begin
          state_d = sha1bsh_pkg::ST_ADD;
        end
      end
      sha1bsh_pkg::ST_ADD: begin
        priority if (last_blk_q) begin
          state_d = sha1bsh_pkg::ST_EMIT;
        end else if (padding_q) begin
          state_d = sha1bsh_pkg::ST_PAD;
        end else begin
          state_d = sha1bsh_pkg::ST_IDLE;
        end
      end
      sha1bsh_pkg::ST_EMIT: begin
        if (dgst_o.ready && emit_cnt_q == sha1bsh_pkg::LastWord) begin
          state_d = sha1bsh_pkg::ST_IDLE;
        end
      end
      default: state_d = sha1bsh_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    pop_o     = (state_q == sha1bsh_pkg::ST_IDLE) && !qstat_i.empty;
    msg_we    = pop_o && has_byte;
    byte_we   = msg_we || (state_q == sha1bsh_pkg::ST_PAD);
    byte_val  = (state_q == sha1bsh_pkg::ST_PAD) ? pad_byte : ent_i.data;
    load_abcd = byte_we && (fill_q == sha1bsh_pkg::LastByte);
    emit_go   = (state_q == sha1bsh_pkg::ST_EMIT) && dgst_o.ready;
  end

  // one round and one schedule word
  assign t_sum = {a_q[26:0], a_q[31:27]} + sha1bsh_pkg::round_f(rnd_q, b_q, c_q, d_q)
               + e_q + sha1bsh_pkg::round_k(rnd_q) + blk_q[0];
  assign w_new = {blk_q[13][30:0] ^ blk_q[8][30:0] ^ blk_q[2][30:0] ^ blk_q[0][30:0],
                  blk_q[13][31] ^ blk_q[8][31] ^ blk_q[2][31] ^ blk_q[0][31]};

  // block buffer and working variables
  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      for (int i = 0; i < sha1bsh_pkg::BlkWords - 1; i++) begin
        blk_q[i] <= {blk_q[i][23:0], blk_q[i+1][31:24]};
      end
      blk_q[sha1bsh_pkg::BlkWords-1] <= {blk_q[sha1bsh_pkg::BlkWords-1][23:0], byte_val};
    end else if (state_q == sha1bsh_pkg::ST_ROUND) begin
      for (int i = 0; i < sha1bsh_pkg::BlkWords - 1; i++) begin
        blk_q[i] <= blk_q[i+1];
      end
      blk_q[sha1bsh_pkg::BlkWords-1] <= w_new;
    end
    if (load_abcd) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (state_q == sha1bsh_pkg::ST_ROUND) begin
      a_q <= t_sum;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  // control, counters and chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha1bsh_pkg::ST_IDLE;
      rnd_q      <= '0;
      fill_q     <= '0;
      len_q      <= '0;
      emit_cnt_q <= '0;
      padding_q  <= 1'b0;
      mark_q     <= 1'b0;
      ovf_q      <= 1'b0;
      last_blk_q <= 1'b0;
      for (int i = 0; i < sha1bsh_pkg::DigWords; i++) begin
        h_q[i] <= sha1bsh_pkg::init_word(sha1bsh_pkg::WordNumW'(i));
      end
    end else begin
      state_q <= state_d;
      if (byte_we) begin
        fill_q <= fill_q + 1'b1;
      end
      if (msg_we) begin
        len_q <= len_q + sha1bsh_pkg::BitsPerByte;
        if (fill_q == sha1bsh_pkg::LastByte) begin
          last_blk_q <= 1'b0;
        end
      end
      if (pop_o && has_end) begin
        padding_q <= 1'b1;
        mark_q    <= 1'b1;
        ovf_q     <= 1'b0;
      end
      if (state_q == sha1bsh_pkg::ST_PAD) begin
        mark_q <= 1'b0;
        if (mark_q) begin
          // marker past the length slots: one extra all-padding block follows
          ovf_q <= (fill_q >= sha1bsh_pkg::LenOffset) && (fill_q != sha1bsh_pkg::LastByte);
        end else if (fill_q == sha1bsh_pkg::LastByte) begin
          ovf_q <= 1'b0;
        end
        if (fill_q == sha1bsh_pkg::LastByte) begin
          last_blk_q <= !mark_q && !ovf_q;
        end
      end
      if (load_abcd) begin
        rnd_q <= '0;
      end else if (state_q == sha1bsh_pkg::ST_ROUND) begin
        rnd_q <= rnd_q + 1'b1;
      end
      if (state_q == sha1bsh_pkg::ST_ADD) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
      end
      if (emit_go) begin
        if (emit_cnt_q == sha1bsh_pkg::LastWord) begin
          emit_cnt_q <= '0;
          len_q      <= '0;
          padding_q  <= 1'b0;
          last_blk_q <= 1'b0;
          for (int i = 0; i < sha1bsh_pkg::DigWords; i++) begin
            h_q[i] <= sha1bsh_pkg::init_word(sha1bsh_pkg::WordNumW'(i));
          end
        end else begin
          emit_cnt_q <= emit_cnt_q + 1'b1;
        end
      end
    end
  end

  assign dgst_o.valid       = (state_q == sha1bsh_pkg::ST_EMIT);
  assign dgst_o.digest_word = h_q[emit_cnt_q];
  assign dgst_o.word_number = emit_cnt_q;
  assign dgst_o.final_word  = (emit_cnt_q == sha1bsh_pkg::LastWord);

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1bsh_pkg::ST_ROUND && rnd_q == sha1bsh_pkg::LastRound)
      |=> state_q == sha1bsh_pkg::ST_ADD)
    else $error("compression did not end after the last round");

  a_emit_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dgst_o.valid |-> (fill_q == '0 && !mark_q && !ovf_q))
    else $error("digest shown with a partly filled block");

  a_emit_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dgst_o.valid) |-> emit_cnt_q == '0)
    else $error("digest does not start at word zero");

endmodule

`default_nettype wire

[src/sha1_byte_stream_hasher.sv]
// sha-1 over a byte stream: message bytes in, five 32-bit digest words out
// message bytes: taken one at a time by the back end; each full 64-byte block is compressed (80 rounds, then an add)
// end of message: pad bytes fill the rest of the block (plus a second pad block when the length does not fit),
//   then compression and five digest words, one per cycle while the sink is ready
// the four-entry queue keeps taking input words while it has room, also while the back end compresses or emits
// reset (async, active low) loads the initial chaining words and clears length and control
`default_nettype none

module sha1_byte_stream_hasher (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha1bsh_in_if.sink    msg_i,
  sha1bsh_out_if.source dgst_o
);

  // front to queue
  logic                 push;
  sha1bsh_pkg::qent_t   push_ent;

  // queue to back end
  logic                 pop;
  sha1bsh_pkg::qent_t   head_ent;
  sha1bsh_pkg::qstat_t  qstat;

  // front: accepts every word while the queue has room, drops words with no flag
  sha1bsh_front u_front (
    .msg_i   (msg_i),
    .qstat_i (qstat),
    .push_o  (push),
    .ent_o   (push_ent)
  );

  // decouples input handshake from the multi-cycle compression
  sha1bsh_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ent_i  (push_ent),
    .pop_i  (pop),
    .ent_o  (head_ent),
    .stat_o (qstat)
  );

  // back end: block buffer, padding, one round per cycle, digest words out
  sha1bsh_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .ent_i   (head_ent),
    .pop_o   (pop),
    .dgst_o  (dgst_o)
  );

endmodule

`default_nettype wire

[dv/sha1_byte_stream_hasher_tb.sv]
// self-checking bench for the sha-1 byte stream hasher: random and directed messages
// depends on sha1bsh_pkg, the channel interfaces in sha1bsh_if.sv and the hasher rtl
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_tb;

  localparam int unsigned HalfPeriod = 4;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned RandItems = 320;
  localparam int unsigned MinMessages = 12;
  // worst message tail: two pad blocks, two compressions and five stalled words
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned CycleLimit = 400000;

  // one input word as the bench queues it
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } msg_item_t;

  // one digest word the hasher should emit
  typedef struct packed {
    sha1bsh_pkg::word_t word;
    logic [2:0]         num;
    logic               fin;
  } digest_due_t;

  logic clk_i;
  logic rst_ni;

  sha1bsh_in_if  msg_if ();
  sha1bsh_out_if dgst_if ();

  sha1_byte_stream_hasher u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .msg_i (msg_if),
    .dgst_o(dgst_if)
  );

  // input words still to be driven, digest words still owed
  msg_item_t   msg_items_todo[$];
  digest_due_t digest_words_due[$];

  int unsigned total_items;
  int unsigned accepted_items;
  int unsigned cycle_count;
  int unsigned mismatches;
  logic        in_taken;

  // predictor state: chaining words, the block being filled and the bit length
  sha1bsh_pkg::word_t hash_words[sha1bsh_pkg::DigWords];
  logic [7:0]         hash_block[64];
  logic [63:0]        hash_bits;

  // clock
  initial clk_i = 1'b0;
  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void hash_restart();
    hash_words[0] = 32'h67452301;
    hash_words[1] = 32'hEFCDAB89;
    hash_words[2] = 32'h98BADCFE;
    hash_words[3] = 32'h10325476;
    hash_words[4] = 32'hC3D2E1F0;
    foreach (hash_block[i]) hash_block[i] = 8'h00;
    hash_bits = 64'd0;
  endfunction

  // 80 rounds over the current block into the chaining words
  function automatic void sha1_compress();
    sha1bsh_pkg::word_t w[80];
    sha1bsh_pkg::word_t a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) begin
      w[i] = {hash_block[4*i], hash_block[4*i+1], hash_block[4*i+2], hash_block[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endfunction

  // one accepted input word: append, and on end of message pad and queue the digest
  function automatic void sha1_absorb(msg_item_t it);
    int          pos;
    logic [63:0] len;
    digest_due_t due;
    if (it.present) begin
      pos = int'(hash_bits[8:3]);
      hash_block[pos] = it.data;
      hash_bits += 64'd8;
      if (pos == 63) sha1_compress();
    end
    if (it.eom) begin
      len = hash_bits;
      pos = int'(hash_bits[8:3]);
      hash_block[pos] = 8'h80;
      pos++;
      // no room left for the length: zero out this block and add one more
      if (pos > 56) begin
        while (pos < 64) begin
          hash_block[pos] = 8'h00;
          pos++;
        end
        sha1_compress();
        pos = 0;
      end
      while (pos < 56) begin
        hash_block[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) hash_block[56+i] = len[63-8*i -: 8];
      sha1_compress();
      for (int i = 0; i < sha1bsh_pkg::DigWords; i++) begin
        due.word = hash_words[i];
        due.num  = 3'(i);
        due.fin  = (3'(i) == sha1bsh_pkg::LastWord);
        digest_words_due.push_back(due);
      end
      hash_restart();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic void queue_item(logic [7:0] data, logic present, logic eom);
    msg_item_t it;
    it.data    = data;
    it.present = present;
    it.eom     = eom;
    msg_items_todo.push_back(it);
  endfunction

  // random message of len bytes with stray ignored words mixed in; returns words that count
  function automatic int unsigned queue_message(int unsigned len);
    int unsigned counted;
    bit          end_on_byte;
    counted = 0;
    end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      queue_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
      counted++;
    end
    // separate end word: its data byte must be ignored
    if (!end_on_byte) begin
      queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      counted++;
    end
    return counted;
  endfunction

  // idle share in percent for the current third of the run
  function automatic int unsigned idle_pct(bit sender);
    int unsigned third;
    third = (total_items == 0) ? 2 : (accepted_items * 3) / total_items;
    case (third)
      0:       return sender ? 16 : 76;
      1:       return sender ? 76 : 16;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: next input word at the falling edge once the previous one is taken
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : msg_driver
    msg_item_t it;
    if (!rst_ni) begin
      msg_if.valid <= 1'b0;
    end else if (!msg_if.valid || in_taken) begin
      if (msg_items_todo.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        it = msg_items_todo.pop_front();
        msg_if.valid          <= 1'b1;
        msg_if.data_byte      <= it.data;
        msg_if.byte_present   <= it.present;
        msg_if.end_of_message <= it.eom;
      end else begin
        msg_if.valid <= 1'b0;
      end
    end
  end

  // digest sink stalls at random too
  always @(negedge clk_i) begin : dgst_stall
    dgst_if.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
  end

  // accepted input words feed the predictor
  always @(posedge clk_i) begin : msg_capture
    msg_item_t it;
    in_taken <= rst_ni && msg_if.valid && msg_if.ready;
    if (rst_ni && msg_if.valid && msg_if.ready) begin
      it.data    = msg_if.data_byte;
      it.present = msg_if.byte_present;
      it.eom     = msg_if.end_of_message;
      sha1_absorb(it);
      accepted_items++;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each digest word against the oldest one owed
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : dgst_monitor
    digest_due_t due;
    if (rst_ni && dgst_if.valid && dgst_if.ready) begin
      if (digest_words_due.size() == 0) begin
        $error("digest word %h with none owed", dgst_if.digest_word);
        mismatches++;
      end else begin
        due = digest_words_due.pop_front();
        if (dgst_if.digest_word !== due.word) begin
          $error("digest_word: expected %h, got %h", due.word, dgst_if.digest_word);
          mismatches++;
        end
        if (dgst_if.word_number !== due.num) begin
          $error("word_number: expected %0d, got %0d", due.num, dgst_if.word_number);
          mismatches++;
        end
        if (dgst_if.final_word !== due.fin) begin
          $error("final_word: expected %0b, got %0b", due.fin, dgst_if.final_word);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[sha1_byte_stream_hasher] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: build all stimulus, reset, then drain
  // ---------------------------------------------------------------------------

  initial begin : run
    int unsigned rand_words;
    int unsigned messages;
    int unsigned len;
    int unsigned edge_lens[9];

    rst_ni                 = 1'b0;
    msg_if.valid           = 1'b0;
    msg_if.data_byte       = 8'h00;
    msg_if.byte_present    = 1'b0;
    msg_if.end_of_message  = 1'b0;
    dgst_if.ready          = 1'b0;
    in_taken               = 1'b0;
    accepted_items         = 0;
    cycle_count            = 0;
    mismatches             = 0;
    hash_restart();

    // empty message: end with no byte
    queue_item(8'h00, 1'b0, 1'b1);
    // neither flag: nothing happens
    queue_item(8'hFF, 1'b0, 1'b0);
    // "abc", end on the last byte
    queue_item(8'h61, 1'b1, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1);
    // "abc" with an ignored byte inside and a separate end word carrying junk
    queue_item(8'h61, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0);
    queue_item(8'h63, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b1);
    // byte extremes and a byte equal to the pad mark
    queue_item(8'h00, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b0);
    queue_item(8'h80, 1'b1, 1'b0);
    queue_item(8'h5A, 1'b0, 1'b1);
    // single byte ending the message on itself
    queue_item(8'hFF, 1'b1, 1'b1);

    // random messages, lengths often at the padding boundaries
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    rand_words = 0;
    messages = 0;
    while (rand_words < RandItems || messages < MinMessages) begin
      if ($urandom_range(0, 9) < 3) len = edge_lens[$urandom_range(0, 8)];
      else len = $urandom_range(0, 30);
      rand_words += queue_message(len);
      messages++;
    end
    total_items = msg_items_todo.size();

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every word handed over, then every digest word back
    while (msg_items_todo.size() != 0 || msg_if.valid) @(posedge clk_i);
    while (digest_words_due.size() != 0) @(posedge clk_i);
    // catch any stray word after the last digest
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);

    if (mismatches == 0) begin
      $display("[sha1_byte_stream_hasher] OK");
    end else begin
      $display("[sha1_byte_stream_hasher] ERROR");
    end
    $finish;
  end

endmodule
